// ----- sv/fwcs_pkg.sv -----
// Package for the flagged weighted complex sum core.
// Holds the accumulator and result record types and fixed constants.
// No dependencies.
`default_nettype none

package fwcs_pkg;

    // Field widths fixed by the stream format
    localparam int ELEM_W   = 8;
    localparam int SAMPLE_W = 24;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 30;
    localparam int WSUM_W   = 22;
    localparam int COUNT_W  = 7;

    // Parts per element before the sums saturate; count tops out here
    localparam int MAX_PARTS = 64;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_PARTS > 127) ? 7'd127 : COUNT_W'(MAX_PARTS);

    // Weight 1.0 in Q8.8
    localparam logic [WEIGHT_W-1:0] ONE_Q8_8 = 16'd256;

    // Configuration register indexes
    localparam logic CFG_MIN_POINTS  = 1'b0;
    localparam logic CFG_USE_WEIGHTS = 1'b1;

    // One accumulator entry as kept in memory
    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic [WSUM_W-1:0]        weight;
        logic signed [SUM_W-1:0]  im;
        logic signed [SUM_W-1:0]  re;
    } acc_t;

    // One finished result waiting for the output side
    typedef struct packed {
        logic                     flagged;
        logic [COUNT_W-1:0]       count;
        logic [WSUM_W-1:0]        weight;
        logic signed [SUM_W-1:0]  im;
        logic signed [SUM_W-1:0]  re;
        logic [ELEM_W-1:0]        element;
    } out_t;

endpackage

`default_nettype wire

// ----- sv/flagged_weighted_complex_sum_core.sv -----
// Flagged weighted complex sum core: per-element masked complex accumulation.
// A result is registered in the update stage, then written into the output queue, from whose head it is offered.
// Throughput: one request per cycle, set by the single read-modify-write pass over
// the accumulator RAM (read at accept, update and write back in the next cycle); the input
// holds off only while the four-entry result queue, counting the update stage, is full.
// Reset clears the pipeline and output queue and loads min_points = 1, use_weights = 1;
// the accumulator RAM is not cleared, an element starts with a first-part request.
// Depends on fwcs_pkg and fwcs_ram.
`default_nettype none

module flagged_weighted_complex_sum_core #(
    parameter int NUM_ELEMENTS = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,

    // Configuration write port
    input  wire logic          cfg_we,
    input  wire logic          cfg_addr,
    input  wire logic [6:0]    cfg_wdata,

    // Input stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // element[7:0], sample_re[31:8], sample_im[55:32], sample_weight[71:56]
    input  wire logic [71:0]   s_axis_tdata,
    // first_part[0], sample_flagged[1], conjugate[2]
    input  wire logic [2:0]    s_axis_tuser,
    input  wire logic          s_axis_tlast,

    // Result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_element[7:0], sum_re[37:8], sum_im[67:38], weight_sum[89:68],
    // point_count[96:90], zeros[103:97]
    output logic [103:0]       m_axis_tdata,
    // result_flagged[0]
    output logic [0:0]         m_axis_tuser
);

    localparam int IDX_W  = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int ACC_W  = $bits(fwcs_pkg::acc_t);
    localparam int OUT_W  = $bits(fwcs_pkg::out_t);

    // Element index to RAM address, wrapping at NUM_ELEMENTS
    function automatic logic [256*IDX_W-1:0] build_idx_tbl();
        logic [256*IDX_W-1:0] tbl;
        int                   r;
        tbl = '0;
        r   = 0;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i*IDX_W +: IDX_W] = IDX_W'(r);
            r = r + 1;
            if (r == NUM_ELEMENTS)
            begin
                r = 0;
            end
        end
        return tbl;
    endfunction

    localparam logic [256*IDX_W-1:0] IDX_TBL = build_idx_tbl();

    // Configuration registers
    logic [fwcs_pkg::COUNT_W-1:0] min_points_reg;
    logic                         use_weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_points_reg  <= 7'd1;
            use_weights_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fwcs_pkg::CFG_MIN_POINTS:  min_points_reg  <= cfg_wdata;
                fwcs_pkg::CFG_USE_WEIGHTS: use_weights_reg <= cfg_wdata[0];
                default:                   min_points_reg  <= min_points_reg;
            endcase
        end
    end

    // Input unpacking
    logic                                  in_accept;
    logic [fwcs_pkg::ELEM_W-1:0]           in_element;
    logic [IDX_W-1:0]                      in_idx;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_element = s_axis_tdata[7:0];
    assign in_idx     = IDX_TBL[int'(in_element)*IDX_W +: IDX_W];

    // Update stage: request fields alongside the RAM read
    logic                                  s1_valid_reg;
    logic [IDX_W-1:0]                      s1_idx_reg;
    logic [fwcs_pkg::ELEM_W-1:0]           s1_elem_reg;
    logic                                  s1_first_reg;
    logic                                  s1_last_reg;
    logic signed [fwcs_pkg::SAMPLE_W-1:0]  s1_re_reg;
    logic signed [fwcs_pkg::SAMPLE_W-1:0]  s1_im_reg;
    logic [fwcs_pkg::WEIGHT_W-1:0]         s1_w_reg;
    logic                                  s1_flag_reg;
    logic                                  s1_conj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_idx_reg   <= in_idx;
            s1_elem_reg  <= in_element;
            s1_first_reg <= s_axis_tuser[0];
            s1_last_reg  <= s_axis_tlast;
            s1_re_reg    <= s_axis_tdata[31:8];
            s1_im_reg    <= s_axis_tdata[55:32];
            s1_w_reg     <= s_axis_tdata[71:56];
            s1_flag_reg  <= s_axis_tuser[1];
            s1_conj_reg  <= s_axis_tuser[2];
        end
    end

    // Accumulator RAM
    logic [ACC_W-1:0]  ram_rdata;
    fwcs_pkg::acc_t    acc_next;

    fwcs_ram #(
        .WIDTH (ACC_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (acc_next),
        .re    (in_accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // Forward last cycle's write-back over a stale read of the same entry
    logic              fwd_valid_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    fwcs_pkg::acc_t    fwd_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_acc_reg <= acc_next;
        end
    end

    // Modify: clear on first part, add unflagged sample with saturation
    fwcs_pkg::acc_t                 acc_base;
    logic signed [24:0]             im_term;
    logic signed [30:0]             re_sum;
    logic signed [30:0]             im_sum;
    logic [22:0]                    w_sum;
    logic [fwcs_pkg::WEIGHT_W-1:0]  w_add;

    always_comb
    begin
        if (s1_first_reg)
        begin
            acc_base = '0;
        end
        else if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            acc_base = fwd_acc_reg;
        end
        else
        begin
            acc_base = fwcs_pkg::acc_t'(ram_rdata);
        end

        im_term = s1_conj_reg ? -25'(s1_im_reg) : 25'(s1_im_reg);
        w_add   = use_weights_reg ? s1_w_reg : fwcs_pkg::ONE_Q8_8;
        re_sum  = 31'(acc_base.re) + 31'(s1_re_reg);
        im_sum  = 31'(acc_base.im) + 31'(im_term);
        w_sum   = {1'b0, acc_base.weight} + 23'(w_add);

        acc_next = acc_base;
        if (!s1_flag_reg)
        begin
            if (re_sum[30] != re_sum[29])
            begin
                acc_next.re = re_sum[30] ? {1'b1, 29'd0} : {1'b0, {29{1'b1}}};
            end
            else
            begin
                acc_next.re = re_sum[29:0];
            end
            if (im_sum[30] != im_sum[29])
            begin
                acc_next.im = im_sum[30] ? {1'b1, 29'd0} : {1'b0, {29{1'b1}}};
            end
            else
            begin
                acc_next.im = im_sum[29:0];
            end
            acc_next.weight = w_sum[22] ? {fwcs_pkg::WSUM_W{1'b1}} : w_sum[21:0];
            if (acc_base.count < fwcs_pkg::COUNT_LIMIT)
            begin
                acc_next.count = acc_base.count + 7'd1;
            end
        end
    end

    // Result record for a last-part request
    fwcs_pkg::out_t result;

    always_comb
    begin
        result.element = s1_elem_reg;
        result.re      = acc_next.re;
        result.im      = acc_next.im;
        result.weight  = acc_next.weight;
        result.count   = acc_next.count;
        result.flagged = (acc_next.count < min_points_reg);
    end

    // Output queue, four entries; room kept for the request in the update stage
    logic [OUT_W-1:0]  q_mem_reg [4];
    logic [1:0]        q_wr_ptr_reg;
    logic [1:0]        q_rd_ptr_reg;
    logic [2:0]        q_cnt_reg;
    logic              q_push;
    logic              q_pop;
    logic [3:0]        q_demand;

    assign q_push   = s1_valid_reg && s1_last_reg;
    assign q_pop    = m_axis_tvalid && m_axis_tready;
    assign q_demand = {1'b0, q_cnt_reg} + {3'd0, q_push};

    assign s_axis_tready = (q_demand < 4'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + 2'd1;
            end
            if (q_pop)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + 2'd1;
            end
            case ({q_push, q_pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + 3'd1;
                2'b01:   q_cnt_reg <= q_cnt_reg - 3'd1;
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_ptr_reg] <= result;
        end
    end

    // Drive the result stream from the queue head
    fwcs_pkg::out_t q_head;

    assign q_head        = fwcs_pkg::out_t'(q_mem_reg[q_rd_ptr_reg]);
    assign m_axis_tvalid = (q_cnt_reg != 3'd0);
    assign m_axis_tdata  = {7'd0, q_head.count, q_head.weight, q_head.im, q_head.re,
                            q_head.element};
    assign m_axis_tuser  = q_head.flagged;

endmodule

`default_nettype wire

// ----- sv/fwcs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-element accumulator store. No package dependency.
`default_nettype none

module fwcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire
